// ----- hdl/lr_pkg.sv -----
// Shared types and constants for the line rasterizer.
package lr_pkg;

   // Fixed payload widths
   localparam int COLOR_BITS = 24;
   localparam int ALPHA_BITS = 8;

   // Alpha value that marks a pixel as drawable
   localparam logic [ALPHA_BITS-1:0] OPAQUE_ALPHA = 8'd255;

   // Request kinds carried on req_type
   typedef enum logic [0:0] {
      REQ_START = 1'b0,
      REQ_STEP  = 1'b1
   } req_kind_type;

   // Controls from the handshake stage to the line engine
   typedef struct packed {
      logic load;
      logic step;
   } lr_ctl_type;

endpackage

// ----- hdl/line_rasterizer.sv -----
// Line rasterizer top level: request register, line setup, line engine and result register.
//
// A start request loads two endpoints, a colour and an alpha and gives no
// result; each step request then gives one pixel of the line, major coordinate
// rising, with last_pixel set on the final one. Steps while no line is active
// give nothing. Requests are taken one per clock: a request is registered, the
// setup or step logic runs between that register and the result register once
// the result register can take a pixel, and the pixel is offered from the result
// register, so a steady stream of steps gives one pixel per clock. The result
// register frees in the same cycle it is taken, so throughput only falls while
// rsp_ready is low.
module line_rasterizer #(
   parameter int COORD_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_type,
   input  logic signed [COORD_BITS-1:0]        req_x_start,
   input  logic signed [COORD_BITS-1:0]        req_y_start,
   input  logic signed [COORD_BITS-1:0]        req_x_end,
   input  logic signed [COORD_BITS-1:0]        req_y_end,
   input  logic [lr_pkg::COLOR_BITS-1:0]       req_color,
   input  logic [lr_pkg::ALPHA_BITS-1:0]       req_alpha,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [COORD_BITS-1:0]        rsp_pixel_x,
   output logic signed [COORD_BITS-1:0]        rsp_pixel_y,
   output logic [lr_pkg::COLOR_BITS-1:0]       rsp_pixel_color,
   output logic                                rsp_draw_enable,
   output logic                                rsp_last_pixel
);
   import lr_pkg::*;

   // Request register
   logic                         req_valid_ff, req_valid_in;
   req_kind_type                 kind_ff;
   logic signed [COORD_BITS-1:0] x_start_ff;
   logic signed [COORD_BITS-1:0] y_start_ff;
   logic signed [COORD_BITS-1:0] x_end_ff;
   logic signed [COORD_BITS-1:0] y_end_ff;
   logic [COLOR_BITS-1:0]        color_ff;
   logic [ALPHA_BITS-1:0]        alpha_ff;

   // Result register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_BITS-1:0] pixel_x_ff;
   logic signed [COORD_BITS-1:0] pixel_y_ff;
   logic [COLOR_BITS-1:0]        pixel_color_ff;
   logic                         draw_enable_ff;
   logic                         last_pixel_ff;

   logic                         req_take;
   logic                         out_free;
   logic                         stage_fire;
   lr_ctl_type                   ctl;

   logic                         set_steep;
   logic signed [COORD_BITS-1:0] set_major_pos;
   logic signed [COORD_BITS-1:0] set_major_end;
   logic signed [COORD_BITS-1:0] set_minor_pos;
   logic                         set_minor_down;
   logic        [COORD_BITS-1:0] set_major_delta;
   logic        [COORD_BITS-1:0] set_minor_delta;

   logic                         eng_active;
   logic signed [COORD_BITS-1:0] eng_pixel_x;
   logic signed [COORD_BITS-1:0] eng_pixel_y;
   logic [COLOR_BITS-1:0]        eng_pixel_color;
   logic                         eng_draw_enable;
   logic                         eng_last_pixel;

   // Handshake: the working stage moves when the result register can take a pixel
   always_comb begin
      out_free   = !rsp_valid_ff || rsp_ready;
      stage_fire = req_valid_ff && out_free;
      req_ready  = !req_valid_ff || stage_fire;
      req_take   = req_valid && req_ready;
      ctl.load   = stage_fire && (kind_ff == REQ_START);
      ctl.step   = stage_fire && (kind_ff == REQ_STEP) && eng_active;
   end

   // Next valid flags
   always_comb begin
      req_valid_in = req_take ? 1'b1 : (stage_fire ? 1'b0 : req_valid_ff);
      rsp_valid_in = ctl.step ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   // Hold control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the request payload on transfer
   always_ff @(posedge clock) begin
      if (req_take) begin
         kind_ff    <= req_kind_type'(req_type);
         x_start_ff <= req_x_start;
         y_start_ff <= req_y_start;
         x_end_ff   <= req_x_end;
         y_end_ff   <= req_y_end;
         color_ff   <= req_color;
         alpha_ff   <= req_alpha;
      end
   end

   lr_setup #(
      .COORD_BITS (COORD_BITS)
   ) u_setup (
      .x_start     (x_start_ff),
      .y_start     (y_start_ff),
      .x_end       (x_end_ff),
      .y_end       (y_end_ff),
      .steep       (set_steep),
      .major_pos   (set_major_pos),
      .major_end   (set_major_end),
      .minor_pos   (set_minor_pos),
      .minor_down  (set_minor_down),
      .major_delta (set_major_delta),
      .minor_delta (set_minor_delta)
   );

   lr_engine #(
      .COORD_BITS (COORD_BITS)
   ) u_engine (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .set_steep       (set_steep),
      .set_major_pos   (set_major_pos),
      .set_major_end   (set_major_end),
      .set_minor_pos   (set_minor_pos),
      .set_minor_down  (set_minor_down),
      .set_major_delta (set_major_delta),
      .set_minor_delta (set_minor_delta),
      .set_color       (color_ff),
      .set_alpha       (alpha_ff),
      .active          (eng_active),
      .pixel_x         (eng_pixel_x),
      .pixel_y         (eng_pixel_y),
      .pixel_color     (eng_pixel_color),
      .draw_enable     (eng_draw_enable),
      .last_pixel      (eng_last_pixel)
   );

   // Capture the pixel when a step produces one
   always_ff @(posedge clock) begin
      if (ctl.step) begin
         pixel_x_ff     <= eng_pixel_x;
         pixel_y_ff     <= eng_pixel_y;
         pixel_color_ff <= eng_pixel_color;
         draw_enable_ff <= eng_draw_enable;
         last_pixel_ff  <= eng_last_pixel;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_x     = pixel_x_ff;
   assign rsp_pixel_y     = pixel_y_ff;
   assign rsp_pixel_color = pixel_color_ff;
   assign rsp_draw_enable = draw_enable_ff;
   assign rsp_last_pixel  = last_pixel_ff;

endmodule

// ----- hdl/lr_setup.sv -----
// Line setup: major axis choice, endpoint ordering and delta computation.
module lr_setup #(
   parameter int COORD_BITS = 12
) (
   input  logic signed [COORD_BITS-1:0] x_start,
   input  logic signed [COORD_BITS-1:0] y_start,
   input  logic signed [COORD_BITS-1:0] x_end,
   input  logic signed [COORD_BITS-1:0] y_end,
   output logic                         steep,
   output logic signed [COORD_BITS-1:0] major_pos,
   output logic signed [COORD_BITS-1:0] major_end,
   output logic signed [COORD_BITS-1:0] minor_pos,
   output logic                         minor_down,
   output logic        [COORD_BITS-1:0] major_delta,
   output logic        [COORD_BITS-1:0] minor_delta
);
   import lr_pkg::*;

   logic signed [COORD_BITS:0]   dx_diff;
   logic signed [COORD_BITS:0]   dy_diff;
   logic signed [COORD_BITS:0]   dx_neg;
   logic signed [COORD_BITS:0]   dy_neg;
   logic        [COORD_BITS-1:0] dx_abs;
   logic        [COORD_BITS-1:0] dy_abs;
   logic signed [COORD_BITS-1:0] ma0;
   logic signed [COORD_BITS-1:0] ma1;
   logic signed [COORD_BITS-1:0] mi0;
   logic signed [COORD_BITS-1:0] mi1;
   logic                         swap;

   // Absolute deltas, from differences one bit wider to hold the full span
   always_comb begin
      dx_diff = {x_end[COORD_BITS-1], x_end} - {x_start[COORD_BITS-1], x_start};
      dy_diff = {y_end[COORD_BITS-1], y_end} - {y_start[COORD_BITS-1], y_start};
      dx_neg  = -dx_diff;
      dy_neg  = -dy_diff;
      dx_abs  = dx_diff[COORD_BITS] ? dx_neg[COORD_BITS-1:0] : dx_diff[COORD_BITS-1:0];
      dy_abs  = dy_diff[COORD_BITS] ? dy_neg[COORD_BITS-1:0] : dy_diff[COORD_BITS-1:0];
   end

   // Pick the major axis; equal deltas go to y
   always_comb begin
      steep = !(dx_abs > dy_abs);
      if (steep) begin
         ma0         = y_start;
         ma1         = y_end;
         mi0         = x_start;
         mi1         = x_end;
         major_delta = dy_abs;
         minor_delta = dx_abs;
      end else begin
         ma0         = x_start;
         ma1         = x_end;
         mi0         = y_start;
         mi1         = y_end;
         major_delta = dx_abs;
         minor_delta = dy_abs;
      end
   end

   // Order the endpoints so that the major coordinate rises
   always_comb begin
      swap       = ma0 > ma1;
      major_pos  = swap ? ma1 : ma0;
      major_end  = swap ? ma0 : ma1;
      minor_pos  = swap ? mi1 : mi0;
      minor_down = swap ? !(mi1 < mi0) : !(mi0 < mi1);
   end

endmodule

// ----- hdl/lr_engine.sv -----
// Line engine: holds the active line and advances it by one pixel per step.
module lr_engine #(
   parameter int COORD_BITS = 12
) (
   input  logic                             clock,
   input  logic                             reset,
   input  lr_pkg::lr_ctl_type               ctl,
   input  logic                             set_steep,
   input  logic signed [COORD_BITS-1:0]     set_major_pos,
   input  logic signed [COORD_BITS-1:0]     set_major_end,
   input  logic signed [COORD_BITS-1:0]     set_minor_pos,
   input  logic                             set_minor_down,
   input  logic        [COORD_BITS-1:0]     set_major_delta,
   input  logic        [COORD_BITS-1:0]     set_minor_delta,
   input  logic [lr_pkg::COLOR_BITS-1:0]    set_color,
   input  logic [lr_pkg::ALPHA_BITS-1:0]    set_alpha,
   output logic                             active,
   output logic signed [COORD_BITS-1:0]     pixel_x,
   output logic signed [COORD_BITS-1:0]     pixel_y,
   output logic [lr_pkg::COLOR_BITS-1:0]    pixel_color,
   output logic                             draw_enable,
   output logic                             last_pixel
);
   import lr_pkg::*;

   localparam int ACC_BITS = COORD_BITS + 2;

   logic                         line_active_ff, line_active_in;
   logic                         steep_line_ff, steep_line_in;
   logic signed [COORD_BITS-1:0] major_pos_ff, major_pos_in;
   logic signed [COORD_BITS-1:0] major_end_ff, major_end_in;
   logic signed [COORD_BITS-1:0] minor_pos_ff, minor_pos_in;
   logic                         minor_down_ff, minor_down_in;
   logic        [COORD_BITS-1:0] major_delta_ff, major_delta_in;
   logic        [COORD_BITS-1:0] minor_delta_ff, minor_delta_in;
   logic signed [ACC_BITS-1:0]   error_acc_ff, error_acc_in;
   logic [COLOR_BITS-1:0]        line_color_ff, line_color_in;
   logic                         opaque_flag_ff, opaque_flag_in;

   logic                         last;
   logic signed [ACC_BITS-1:0]   acc_sum;
   logic signed [ACC_BITS:0]     acc_twice;
   logic signed [ACC_BITS:0]     major_wide;
   logic                         minor_move;

   // Current pixel from the held state
   always_comb begin
      last        = major_pos_ff >= major_end_ff;
      pixel_x     = steep_line_ff ? minor_pos_ff : major_pos_ff;
      pixel_y     = steep_line_ff ? major_pos_ff : minor_pos_ff;
      pixel_color = line_color_ff;
      draw_enable = opaque_flag_ff;
      last_pixel  = last;
      active      = line_active_ff;
   end

   // Error term for the next pixel
   always_comb begin
      acc_sum    = error_acc_ff + $signed({2'b00, minor_delta_ff});
      acc_twice  = {acc_sum, 1'b0};
      major_wide = $signed({3'b000, major_delta_ff});
      minor_move = acc_twice >= major_wide;
   end

   // Load a new line or advance the active one
   always_comb begin
      line_active_in = line_active_ff;
      steep_line_in  = steep_line_ff;
      major_pos_in   = major_pos_ff;
      major_end_in   = major_end_ff;
      minor_pos_in   = minor_pos_ff;
      minor_down_in  = minor_down_ff;
      major_delta_in = major_delta_ff;
      minor_delta_in = minor_delta_ff;
      error_acc_in   = error_acc_ff;
      line_color_in  = line_color_ff;
      opaque_flag_in = opaque_flag_ff;
      if (ctl.load) begin
         line_active_in = 1'b1;
         steep_line_in  = set_steep;
         major_pos_in   = set_major_pos;
         major_end_in   = set_major_end;
         minor_pos_in   = set_minor_pos;
         minor_down_in  = set_minor_down;
         major_delta_in = set_major_delta;
         minor_delta_in = set_minor_delta;
         error_acc_in   = '0;
         line_color_in  = set_color;
         opaque_flag_in = set_alpha == OPAQUE_ALPHA;
      end else if (ctl.step) begin
         if (last) begin
            line_active_in = 1'b0;
         end else begin
            major_pos_in = major_pos_ff + COORD_BITS'(1);
            if (minor_move) begin
               minor_pos_in = minor_down_ff ? minor_pos_ff - COORD_BITS'(1)
                                            : minor_pos_ff + COORD_BITS'(1);
               error_acc_in = acc_sum - $signed({2'b00, major_delta_ff});
            end else begin
               error_acc_in = acc_sum;
            end
         end
      end
   end

   // Hold line state
   always_ff @(posedge clock) begin
      if (reset) begin
         line_active_ff <= 1'b0;
         steep_line_ff  <= 1'b0;
         major_pos_ff   <= '0;
         major_end_ff   <= '0;
         minor_pos_ff   <= '0;
         minor_down_ff  <= 1'b0;
         major_delta_ff <= '0;
         minor_delta_ff <= '0;
         error_acc_ff   <= '0;
         line_color_ff  <= '0;
         opaque_flag_ff <= 1'b0;
      end else begin
         line_active_ff <= line_active_in;
         steep_line_ff  <= steep_line_in;
         major_pos_ff   <= major_pos_in;
         major_end_ff   <= major_end_in;
         minor_pos_ff   <= minor_pos_in;
         minor_down_ff  <= minor_down_in;
         major_delta_ff <= major_delta_in;
         minor_delta_ff <= minor_delta_in;
         error_acc_ff   <= error_acc_in;
         line_color_ff  <= line_color_in;
         opaque_flag_ff <= opaque_flag_in;
      end
   end

endmodule

// ----- hdl/lr_checker.sv -----
// Port-level checks for the line rasterizer, bound to the top level.
module lr_checker #(
   parameter int COORD_BITS = 12
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [COORD_BITS-1:0]  rsp_pixel_x,
   input logic signed [COORD_BITS-1:0]  rsp_pixel_y,
   input logic [lr_pkg::COLOR_BITS-1:0] rsp_pixel_color,
   input logic                          rsp_draw_enable,
   input logic                          rsp_last_pixel
);
   import lr_pkg::*;

   // No pixel is offered straight after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered after reset");

   // A stalled pixel holds until its transfer
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_x)
         && $stable(rsp_pixel_y) && $stable(rsp_pixel_color)
         && $stable(rsp_draw_enable) && $stable(rsp_last_pixel))
      else $error("stalled result changed");

   // Requests are only refused while a pixel is stalled at the output
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request refused without output stall");

   // With the output empty the block keeps taking requests
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request refused with empty output");

   // An offered request is never refused while the output drains
   assert property (@(posedge clock) disable iff (reset)
      req_valid && rsp_ready |-> req_ready)
      else $error("request refused while output drains");

endmodule

bind line_rasterizer lr_checker #(
   .COORD_BITS (COORD_BITS)
) u_lr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_pixel_x     (rsp_pixel_x),
   .rsp_pixel_y     (rsp_pixel_y),
   .rsp_pixel_color (rsp_pixel_color),
   .rsp_draw_enable (rsp_draw_enable),
   .rsp_last_pixel  (rsp_last_pixel)
);
